// ----- hw/rtl/krt_pkg.sv -----
// Shared types, operation codes and status codes for the keyed record table.
// No dependencies.
`default_nettype none

package krt_pkg;

   // Operation codes carried in the request beat
   localparam logic [2:0] FN_INSERT = 3'd0;
   localparam logic [2:0] FN_LIST   = 3'd1;
   localparam logic [2:0] FN_LOOKUP = 3'd2;
   localparam logic [2:0] FN_UPDATE = 3'd3;
   localparam logic [2:0] FN_REMOVE = 3'd4;

   // Status codes carried in the response beat
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_FULL     = 3'd1;
   localparam logic [2:0] STS_DUP      = 3'd2;
   localparam logic [2:0] STS_NONPOS   = 3'd3;
   localparam logic [2:0] STS_NOTFOUND = 3'd4;
   localparam logic [2:0] STS_EMPTY    = 3'd5;

   // Most response beats one list operation produces
   localparam int unsigned OUT_MAX = 16;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] key;
      logic [15:0]        new_year;
      logic [63:0]        new_title;
      logic [63:0]        new_director;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         position;
      logic signed [31:0] found_key;
      logic [15:0]        found_year;
      logic [63:0]        found_title;
      logic [63:0]        found_director;
      logic [4:0]         occupancy;
      logic               last;
   } rsp_type;

   // One stored record, as held in the table memory
   typedef struct packed {
      logic signed [31:0] key;
      logic [15:0]        year;
      logic [63:0]        title;
      logic [63:0]        director;
   } rec_type;

   localparam int unsigned REC_W = $bits(rec_type);

   function automatic rec_type mk_rec(req_type r);
      rec_type v;
      v.key      = r.key;
      v.year     = r.new_year;
      v.title    = r.new_title;
      v.director = r.new_director;
      return v;
   endfunction

   function automatic rsp_type mk_rsp(logic [2:0] status, logic [3:0] pos, rec_type rec,
                                      logic [4:0] occ, logic last);
      rsp_type v;
      v.status         = status;
      v.position       = pos;
      v.found_key      = rec.key;
      v.found_year     = rec.year;
      v.found_title    = rec.title;
      v.found_director = rec.director;
      v.occupancy      = occ;
      v.last           = last;
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/krt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module krt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_record_table_unit.sv -----
// Top level of the keyed record table: request decode, search/list/compaction
// sequencer and response register. Uses krt_pkg and krt_ram.
`default_nettype none

// Keyed record table. Holds up to TABLE_DEPTH records (key, year, two 64-bit
// payload words) in insertion order in one synchronous RAM. A request beat is
// taken when start is high and busy is low; each response beat appears on
// rsp_item for exactly one cycle with rsp_valid high, and the receiver cannot
// hold it off. A request that needs no table walk (full table, nonpositive key,
// empty table, insert into an empty table) puts its beat out in the next cycle
// and leaves busy low; an unused code is dropped with no beat. Insert, lookup,
// update and remove walk the keys from slot 0 through the RAM's single read
// port: issue the first read, wait for the registered read data, then compare
// one slot per cycle. List emits one beat per cycle for the first min(n,16)
// records, with n the records held. Remove then shifts later records down one
// slot per cycle (read one slot ahead, write back), keeping busy high until the
// last record has moved when any record lies above the matched slot; its
// response beat goes out when the match is found. The longest requests are
// removes that leave records to shift down. The table memory has no reset;
// only slots below the record count are ever read back.
module keyed_record_table_unit #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire krt_pkg::req_type req_item,
   output logic                  rsp_valid,
   output krt_pkg::rsp_type      rsp_item
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SEARCH  = 2'd1;
   localparam logic [1:0] ST_LIST    = 2'd2;
   localparam logic [1:0] ST_COMPACT = 2'd3;

   logic [1:0]       state_ff, state_in;
   krt_pkg::req_type req_ff, req_in;
   logic [CW-1:0]    cnt_ff, cnt_in;      // records held
   logic [CW-1:0]    iss_ff, iss_in;      // slot whose read is issued this cycle
   logic             cmp_vld_ff, cmp_vld_in; // read data valid this cycle
   logic [CW-1:0]    cmp_idx_ff, cmp_idx_in; // slot the read data belongs to
   logic [CW-1:0]    lim_ff, lim_in;      // list length
   logic             rsp_vld_ff, rsp_vld_in;
   krt_pkg::rsp_type rsp_ff, rsp_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   krt_pkg::rec_type           wr_rec;
   logic [krt_pkg::REC_W-1:0]  rd_data;
   krt_pkg::rec_type           rd_rec;
   krt_pkg::rec_type           upd_rec;
   krt_pkg::rec_type           zero_rec;
   logic [CW-1:0]              dst_idx;
   logic                       req_nonpos;

   krt_ram #(
      .WIDTH (krt_pkg::REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (iss_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_rec     = krt_pkg::rec_type'(rd_data);
   assign zero_rec   = '0;
   assign dst_idx    = cmp_idx_ff - ONE_C;
   assign req_nonpos = req_item.key[31] || (req_item.key == '0);

   // Update keeps the stored key and takes the new year and payload
   always_comb begin
      upd_rec          = krt_pkg::mk_rec(req_ff);
      upd_rec.key      = rd_rec.key;
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      cnt_in     = cnt_ff;
      iss_in     = iss_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = iss_ff;
      lim_in     = lim_ff;
      rsp_vld_in = 1'b0;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = cnt_ff[AW-1:0];
      wr_rec     = krt_pkg::mk_rec(req_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               iss_in = '0;
               case (req_item.func)
                  krt_pkg::FN_INSERT: begin
                     if (cnt_ff >= DEPTH_C) begin
                        rsp_vld_in = 1'b1;
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_FULL, 4'd0, zero_rec,
                                                 5'(cnt_ff), 1'b1);
                     end else if (req_nonpos) begin
                        // stored keys are all positive, so no duplicate is possible
                        rsp_vld_in = 1'b1;
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_NONPOS, 4'd0, zero_rec,
                                                 5'(cnt_ff), 1'b1);
                     end else if (cnt_ff == '0) begin
                        // empty table: append at slot 0 without a walk
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_rec     = krt_pkg::mk_rec(req_item);
                        cnt_in     = ONE_C;
                        rsp_vld_in = 1'b1;
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_OK, 4'd0,
                                                 krt_pkg::mk_rec(req_item), 5'd1, 1'b1);
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  krt_pkg::FN_LIST: begin
                     if (cnt_ff == '0) begin
                        rsp_vld_in = 1'b1;
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_EMPTY, 4'd0, zero_rec,
                                                 5'd0, 1'b1);
                     end else begin
                        if (32'(cnt_ff) > 32'(krt_pkg::OUT_MAX)) begin
                           lim_in = CW'(krt_pkg::OUT_MAX);
                        end else begin
                           lim_in = cnt_ff;
                        end
                        state_in = ST_LIST;
                     end
                  end
                  krt_pkg::FN_LOOKUP, krt_pkg::FN_UPDATE, krt_pkg::FN_REMOVE: begin
                     if (cnt_ff == '0) begin
                        rsp_vld_in = 1'b1;
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_EMPTY, 4'd0, zero_rec,
                                                 5'd0, 1'b1);
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  default: begin
                     // unused codes: drop the beat, no response
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            // advance the read pointer one slot per cycle
            if (iss_ff < cnt_ff) begin
               cmp_vld_in = 1'b1;
               iss_in     = iss_ff + ONE_C;
            end
            if (cmp_vld_ff) begin
               if (rd_rec.key == req_ff.key) begin
                  cmp_vld_in = 1'b0;
                  state_in   = ST_IDLE;
                  rsp_vld_in = 1'b1;
                  case (req_ff.func)
                     krt_pkg::FN_INSERT: begin
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_DUP, 4'(cmp_idx_ff), rd_rec,
                                                 5'(cnt_ff), 1'b1);
                     end
                     krt_pkg::FN_UPDATE: begin
                        wr_en   = 1'b1;
                        wr_addr = cmp_idx_ff[AW-1:0];
                        wr_rec  = upd_rec;
                        rsp_in  = krt_pkg::mk_rsp(krt_pkg::STS_OK, 4'(cmp_idx_ff), upd_rec,
                                                  5'(cnt_ff), 1'b1);
                     end
                     krt_pkg::FN_REMOVE: begin
                        cnt_in = cnt_ff - ONE_C;
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_OK, 4'(cmp_idx_ff), rd_rec,
                                                 5'(cnt_ff - ONE_C), 1'b1);
                        // shift later records down, starting one slot above
                        if ((cmp_idx_ff + ONE_C) < cnt_ff) begin
                           state_in = ST_COMPACT;
                           iss_in   = cmp_idx_ff + ONE_C;
                        end
                     end
                     default: begin
                        rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_OK, 4'(cmp_idx_ff), rd_rec,
                                                 5'(cnt_ff), 1'b1);
                     end
                  endcase
               end else if (cmp_idx_ff == (cnt_ff - ONE_C)) begin
                  // walked every record without a match
                  cmp_vld_in = 1'b0;
                  state_in   = ST_IDLE;
                  rsp_vld_in = 1'b1;
                  if (req_ff.func == krt_pkg::FN_INSERT) begin
                     wr_en   = 1'b1;
                     wr_addr = cnt_ff[AW-1:0];
                     cnt_in  = cnt_ff + ONE_C;
                     rsp_in  = krt_pkg::mk_rsp(krt_pkg::STS_OK, 4'(cnt_ff),
                                               krt_pkg::mk_rec(req_ff),
                                               5'(cnt_ff + ONE_C), 1'b1);
                  end else begin
                     rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_NOTFOUND, 4'd0, zero_rec,
                                              5'(cnt_ff), 1'b1);
                  end
               end
            end
         end

         ST_LIST: begin
            if (iss_ff < lim_ff) begin
               cmp_vld_in = 1'b1;
               iss_in     = iss_ff + ONE_C;
            end
            if (cmp_vld_ff) begin
               rsp_vld_in = 1'b1;
               rsp_in = krt_pkg::mk_rsp(krt_pkg::STS_OK, 4'(cmp_idx_ff), rd_rec,
                                        5'(cnt_ff), cmp_idx_ff == (lim_ff - ONE_C));
               if (cmp_idx_ff == (lim_ff - ONE_C)) begin
                  cmp_vld_in = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end

         ST_COMPACT: begin
            // cnt_ff already holds the reduced count; last source slot equals it
            if (iss_ff <= cnt_ff) begin
               cmp_vld_in = 1'b1;
               iss_in     = iss_ff + ONE_C;
            end
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_idx[AW-1:0];
               wr_rec  = rd_rec;
               if (cmp_idx_ff == cnt_ff) begin
                  cmp_vld_in = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      req_ff     <= req_in;
      iss_ff     <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      lim_ff     <= lim_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking bench for keyed_record_table_unit: a directed table, then random
// insert/list/lookup/update/remove traffic checked against a shadow record table.
// Depends on krt_pkg and the keyed_record_table_unit RTL.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS  = 16;
   localparam int RANDOM_ITEMS = 200;
   // Longest requests are removes that compact a full table
   localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 8;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_mode_type;

   // One row of the directed table; want is used only where typed is set
   typedef struct {
      krt_pkg::req_type req;
      bit               typed;
      krt_pkg::rsp_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   krt_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_valid;
   krt_pkg::rsp_type rsp_item;

   // Shadow copy of the table contents and record count
   krt_pkg::rec_type shadow_tbl [TABLE_SLOTS];
   int               shadow_count = 0;
   int               peak_count = 0;

   krt_pkg::rsp_type op_beats[$];        // beats the current request produces
   krt_pkg::rsp_type expected_beats[$];  // beats still owed by the block, oldest first

   // Typed expectation of the request now on the bus
   bit               row_typed = 1'b0;
   krt_pkg::rsp_type row_want = '0;

   int unsigned errors_seen = 0;
   int unsigned accepted = 0;
   int unsigned beats_checked = 0;
   int unsigned status_seen [8];

   keyed_record_table_unit #(
      .TABLE_DEPTH(TABLE_SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case a beat never arrives or the block hangs busy
   initial begin
      #3ms;
      $display("testbench: errors");
      $finish;
   end

   function automatic krt_pkg::rsp_type rsp_of(logic [2:0] st, logic [3:0] pos,
                                               logic signed [31:0] k, logic [15:0] y,
                                               logic [63:0] t, logic [63:0] d,
                                               logic [4:0] occ, logic lst);
      krt_pkg::rsp_type v;
      v.status         = st;
      v.position       = pos;
      v.found_key      = k;
      v.found_year     = y;
      v.found_title    = t;
      v.found_director = d;
      v.occupancy      = occ;
      v.last           = lst;
      return v;
   endfunction

   function automatic krt_pkg::req_type req_of(logic [2:0] f, logic signed [31:0] k,
                                               logic [15:0] y, logic [63:0] t,
                                               logic [63:0] d);
      krt_pkg::req_type v;
      v.func         = f;
      v.key          = k;
      v.new_year     = y;
      v.new_title    = t;
      v.new_director = d;
      return v;
   endfunction

   // Linear search from slot 0; -1 when the key is not held
   function automatic int find_slot(logic signed [31:0] k);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_tbl[i].key == k) return i;
      end
      return -1;
   endfunction

   // Beat reporting the record held in one slot
   function automatic krt_pkg::rsp_type rec_beat(logic [2:0] st, int slot, logic lst);
      return rsp_of(st, 4'(slot), shadow_tbl[slot].key, shadow_tbl[slot].year,
                    shadow_tbl[slot].title, shadow_tbl[slot].director,
                    5'(shadow_count), lst);
   endfunction

   // Beat with no record attached (rejects, misses, empty table)
   function automatic krt_pkg::rsp_type bare_beat(logic [2:0] st);
      return rsp_of(st, 4'd0, 32'sd0, 16'd0, 64'd0, 64'd0, 5'(shadow_count), 1'b1);
   endfunction

   // Apply one request to the shadow table and collect the beats it causes
   task automatic table_apply(input krt_pkg::req_type r);
      int               slot;
      int               n;
      krt_pkg::rec_type gone;
      op_beats.delete();
      if (r.func > krt_pkg::FN_REMOVE) return;   // unused codes: drop silently
      if (r.func == krt_pkg::FN_INSERT) begin
         slot = find_slot(r.key);
         if (shadow_count >= TABLE_SLOTS) begin
            op_beats.push_back(bare_beat(krt_pkg::STS_FULL));
         end else if (slot >= 0) begin
            op_beats.push_back(rec_beat(krt_pkg::STS_DUP, slot, 1'b1));
         end else if (r.key <= 0) begin
            op_beats.push_back(bare_beat(krt_pkg::STS_NONPOS));
         end else begin
            shadow_tbl[shadow_count].key      = r.key;
            shadow_tbl[shadow_count].year     = r.new_year;
            shadow_tbl[shadow_count].title    = r.new_title;
            shadow_tbl[shadow_count].director = r.new_director;
            shadow_count++;
            if (shadow_count > peak_count) peak_count = shadow_count;
            op_beats.push_back(rec_beat(krt_pkg::STS_OK, shadow_count - 1, 1'b1));
         end
      end else if (shadow_count == 0) begin
         op_beats.push_back(bare_beat(krt_pkg::STS_EMPTY));
      end else if (r.func == krt_pkg::FN_LIST) begin
         n = (shadow_count < krt_pkg::OUT_MAX) ? shadow_count : krt_pkg::OUT_MAX;
         for (int i = 0; i < n; i++)
            op_beats.push_back(rec_beat(krt_pkg::STS_OK, i, i == n - 1));
      end else begin
         slot = find_slot(r.key);
         if (slot < 0) begin
            op_beats.push_back(bare_beat(krt_pkg::STS_NOTFOUND));
         end else if (r.func == krt_pkg::FN_LOOKUP) begin
            op_beats.push_back(rec_beat(krt_pkg::STS_OK, slot, 1'b1));
         end else if (r.func == krt_pkg::FN_UPDATE) begin
            shadow_tbl[slot].year     = r.new_year;
            shadow_tbl[slot].title    = r.new_title;
            shadow_tbl[slot].director = r.new_director;
            op_beats.push_back(rec_beat(krt_pkg::STS_OK, slot, 1'b1));
         end else begin
            // Remove: report the record and its old slot, then compact
            gone = shadow_tbl[slot];
            for (int i = slot; i + 1 < shadow_count; i++) shadow_tbl[i] = shadow_tbl[i + 1];
            shadow_count--;
            op_beats.push_back(rsp_of(krt_pkg::STS_OK, 4'(slot), gone.key, gone.year,
                                      gone.title, gone.director, 5'(shadow_count), 1'b1));
         end
      end
   endtask

   task automatic check_beat(input krt_pkg::rsp_type exp, input krt_pkg::rsp_type act);
      bit bad;
      bad = 1'b0;
      if (act.status !== exp.status) begin
         $error("status: expected %0d, got %0d", exp.status, act.status);
         bad = 1'b1;
      end
      if (act.position !== exp.position) begin
         $error("position: expected %0d, got %0d", exp.position, act.position);
         bad = 1'b1;
      end
      if (act.found_key !== exp.found_key) begin
         $error("found_key: expected %0d, got %0d", exp.found_key, act.found_key);
         bad = 1'b1;
      end
      if (act.found_year !== exp.found_year) begin
         $error("found_year: expected %0d, got %0d", exp.found_year, act.found_year);
         bad = 1'b1;
      end
      if (act.found_title !== exp.found_title) begin
         $error("found_title: expected %h, got %h", exp.found_title, act.found_title);
         bad = 1'b1;
      end
      if (act.found_director !== exp.found_director) begin
         $error("found_director: expected %h, got %h", exp.found_director,
                act.found_director);
         bad = 1'b1;
      end
      if (act.occupancy !== exp.occupancy) begin
         $error("occupancy: expected %0d, got %0d", exp.occupancy, act.occupancy);
         bad = 1'b1;
      end
      if (act.last !== exp.last) begin
         $error("last: expected %0d, got %0d", exp.last, act.last);
         bad = 1'b1;
      end
      if (bad) errors_seen++;
      beats_checked++;
      status_seen[exp.status]++;
   endtask

   // Sample both channels at the rising edge. Check the response first: a beat
   // out in the same cycle as an acceptance always belongs to an older request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               $error("response beat with nothing expected (status %0d)", rsp_item.status);
               errors_seen++;
            end else begin
               check_beat(expected_beats.pop_front(), rsp_item);
            end
         end
         if (start && !busy) begin
            table_apply(req_item);
            accepted++;
            // Typed rows stand in for the shadow table's beat; the shadow table
            // is still advanced so later rows see the same contents.
            if (row_typed) expected_beats.push_back(row_want);
            else foreach (op_beats[i]) expected_beats.push_back(op_beats[i]);
         end
      end
   end

   // Present one request beat after gap idle cycles and hold it until taken.
   // Called and returns at a falling edge; start stays high when gap is zero.
   task automatic send_beat(input krt_pkg::req_type r, input int gap, input bit typed,
                            input krt_pkg::rsp_type w);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed = typed;
      row_want  = w;
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      stim_row_type           rows[$];
      stim_row_type           sr;
      mix_mode_type           mode;
      int                     real_items;
      int                     burst_left;
      int                     gap;
      int                     pick;
      logic [2:0]             f;
      logic signed [31:0]     k;
      logic [63:0]            ones;

      ones = '1;

      // Directed table: empty-table cases, key extremes, unused codes, then
      // every operation on a two-record table. Typed rows are easy to read off.
      sr.typed = 1'b1;
      sr.req = req_of(krt_pkg::FN_LOOKUP, 32'sd5, 16'd0, 64'd0, 64'd0);
      sr.want = rsp_of(krt_pkg::STS_EMPTY, 4'd0, 32'sd0, 16'd0, 64'd0, 64'd0, 5'd0, 1'b1);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_LIST, 32'sd0, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_UPDATE, 32'sd5, 16'd7, 64'd1, 64'd2);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_REMOVE, 32'sd5, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.want.status = krt_pkg::STS_NONPOS;
      sr.req = req_of(krt_pkg::FN_INSERT, 32'sd0, 16'd1, 64'd1, 64'd1);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_INSERT, 32'sh8000_0000, 16'hffff, ones, ones);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_INSERT, -32'sd1, 16'd3, 64'd3, 64'd3);
      rows.push_back(sr);
      sr.typed = 1'b0;
      sr.req = req_of(3'd5, 32'sd9, 16'd9, 64'd9, 64'd9);
      rows.push_back(sr);
      sr.req = req_of(3'd7, 32'sh7fff_ffff, 16'hffff, ones, ones);
      rows.push_back(sr);
      sr.typed = 1'b1;
      sr.req = req_of(krt_pkg::FN_INSERT, 32'sh7fff_ffff, 16'hffff, ones, ones);
      sr.want = rsp_of(krt_pkg::STS_OK, 4'd0, 32'sh7fff_ffff, 16'hffff, ones, ones, 5'd1,
                       1'b1);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_INSERT, 32'sd1, 16'd0, 64'd0, 64'd0);
      sr.want = rsp_of(krt_pkg::STS_OK, 4'd1, 32'sd1, 16'd0, 64'd0, 64'd0, 5'd2, 1'b1);
      rows.push_back(sr);
      // Duplicate reports the record already holding the key
      sr.req = req_of(krt_pkg::FN_INSERT, 32'sd1, 16'd55, 64'h55, 64'h66);
      sr.want.status = krt_pkg::STS_DUP;
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_INSERT, -32'sd5, 16'd1, 64'd1, 64'd1);
      sr.want = rsp_of(krt_pkg::STS_NONPOS, 4'd0, 32'sd0, 16'd0, 64'd0, 64'd0, 5'd2, 1'b1);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_LOOKUP, 32'sh7fff_ffff, 16'd0, 64'd0, 64'd0);
      sr.want = rsp_of(krt_pkg::STS_OK, 4'd0, 32'sh7fff_ffff, 16'hffff, ones, ones, 5'd2,
                       1'b1);
      rows.push_back(sr);
      sr.want = rsp_of(krt_pkg::STS_NOTFOUND, 4'd0, 32'sd0, 16'd0, 64'd0, 64'd0, 5'd2,
                       1'b1);
      sr.req = req_of(krt_pkg::FN_LOOKUP, 32'sd2, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_LOOKUP, -32'sd1, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_UPDATE, 32'sd9, 16'd9, 64'd9, 64'd9);
      rows.push_back(sr);
      sr.typed = 1'b0;
      sr.req = req_of(krt_pkg::FN_UPDATE, 32'sd1, 16'd1999, 64'h0123_4567_89ab_cdef,
                      64'hfedc_ba98_7654_3210);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_LIST, 32'sd0, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_INSERT, 32'sd2, 16'd2024, 64'haaaa_5555_aaaa_5555,
                      64'h5555_aaaa_5555_aaaa);
      rows.push_back(sr);
      // Remove slot 0 so both later records shift down
      sr.req = req_of(krt_pkg::FN_REMOVE, 32'sh7fff_ffff, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.typed = 1'b1;
      sr.req = req_of(krt_pkg::FN_REMOVE, 32'sh7fff_ffff, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.typed = 1'b0;
      sr.req = req_of(krt_pkg::FN_REMOVE, 32'sd2, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);
      sr.req = req_of(3'd6, 32'sd1, 16'd1, 64'd1, 64'd1);
      rows.push_back(sr);
      sr.req = req_of(krt_pkg::FN_LIST, 32'sd0, 16'd0, 64'd0, 64'd0);
      rows.push_back(sr);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_beat(rows[i].req, $urandom_range(0, 12), rows[i].typed,
                                  rows[i].want);

      // Random traffic. Start by filling the table, then drift between fill,
      // drain and mixed phases so full tables, long lists and deep compactions
      // all come up. Most keys come from a small pool or the held keys so that
      // lookups, updates, removes and duplicates actually hit.
      mode = MIX_FILL;
      real_items = 0;
      burst_left = 0;
      while (real_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) mode = mix_mode_type'($urandom_range(0, 2));
         if (mode == MIX_FILL && shadow_count == TABLE_SLOTS && $urandom_range(0, 5) == 0)
            mode = MIX_DRAIN;
         if (mode == MIX_DRAIN && shadow_count == 0 && $urandom_range(0, 2) == 0)
            mode = MIX_FILL;

         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            f = 3'($urandom_range(5, 7));   // noise: unused codes
         end else begin
            pick = $urandom_range(0, 99);
            case (mode)
               MIX_FILL: begin
                  if (pick < 70)      f = krt_pkg::FN_INSERT;
                  else if (pick < 78) f = krt_pkg::FN_LOOKUP;
                  else if (pick < 86) f = krt_pkg::FN_UPDATE;
                  else if (pick < 92) f = krt_pkg::FN_LIST;
                  else                f = krt_pkg::FN_REMOVE;
               end
               MIX_DRAIN: begin
                  if (pick < 55)      f = krt_pkg::FN_REMOVE;
                  else if (pick < 70) f = krt_pkg::FN_LOOKUP;
                  else if (pick < 80) f = krt_pkg::FN_UPDATE;
                  else if (pick < 90) f = krt_pkg::FN_LIST;
                  else                f = krt_pkg::FN_INSERT;
               end
               default: f = 3'($urandom_range(0, 4));
            endcase
         end

         pick = $urandom_range(0, 99);
         if (f == krt_pkg::FN_INSERT) begin
            if (pick < 60) begin
               k = ($urandom_range(0, 19) == 0) ? 32'sh7fff_ffff : $urandom_range(1, 40);
            end else if (pick < 75 && shadow_count > 0) begin
               k = shadow_tbl[$urandom_range(0, shadow_count - 1)].key;
            end else if (pick < 85) begin
               case ($urandom_range(0, 3))
                  0:       k = 32'sd0;
                  1:       k = 32'sh8000_0000;
                  2:       k = -$signed(32'($urandom_range(1, 1000)));
                  default: k = {1'b1, 31'($urandom)};
               endcase
            end else begin
               k = $urandom;
            end
         end else begin
            if (pick < 70 && shadow_count > 0)
               k = shadow_tbl[$urandom_range(0, shadow_count - 1)].key;
            else if (pick < 85)
               k = $urandom_range(1, 40);
            else
               k = $urandom;
         end

         // Mostly random gaps, with bursts of back-to-back requests
         if (burst_left > 0) begin
            gap = 0;
            burst_left--;
         end else begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 24);
         end

         if (f <= krt_pkg::FN_REMOVE) real_items++;
         send_beat(req_of(f, k, 16'($urandom), {$urandom, $urandom}, {$urandom, $urandom}),
                   gap, 1'b0, '0);
      end
      start <= 1'b0;

      // Drain: wait for every owed beat, then let a remove's compaction finish
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d response beats, peak table depth %0d",
               accepted, beats_checked, peak_count);
      $display("rejects: full %0d, duplicate %0d, nonpositive %0d, not found %0d, empty %0d",
               status_seen[krt_pkg::STS_FULL], status_seen[krt_pkg::STS_DUP],
               status_seen[krt_pkg::STS_NONPOS], status_seen[krt_pkg::STS_NOTFOUND],
               status_seen[krt_pkg::STS_EMPTY]);
      if (errors_seen == 0 && expected_beats.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/krt_pkg.sv
hw/rtl/krt_ram.sv
hw/rtl/keyed_record_table_unit.sv
sim/testbench.sv
